@@ rtl/altitude_kalman_estimator_core_macros.svh @@
`ifndef ALTITUDE_KALMAN_ESTIMATOR_CORE_MACROS_SVH
`define ALTITUDE_KALMAN_ESTIMATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AKE_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AKE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ake_pkg.sv @@
package ake_pkg;

	// opcodes
	localparam logic [1:0] OP_INIT    = 2'd0;
	localparam logic [1:0] OP_PREDICT = 2'd1;
	localparam logic [1:0] OP_UPDATE  = 2'd2;

	// config register indexes
	localparam logic [1:0] CFG_QVAR = 2'd0;
	localparam logic [1:0] CFG_RVAR = 2'd1;
	localparam logic [1:0] CFG_ALT0 = 2'd2;
	localparam logic [1:0] CFG_VEL0 = 2'd3;

	localparam logic [30:0] QVAR_RST = 31'd65536;
	localparam logic [30:0] RVAR_RST = 31'd65536;
	localparam logic signed [47:0] COV_TEN = 48'sd167772160;
	localparam logic signed [65:0] S_MIN = 66'sd17;
	localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
	localparam logic signed [65:0] S48_MAX = 66'sd140737488355327;
	localparam logic signed [65:0] S48_MIN = -66'sd140737488355328;
	localparam logic [96:0] PROD_CAP = 97'd1 << 62;
	localparam logic [46:0] GAIN_MAX = {47{1'b1}};

	// micro-op kinds
	localparam logic [2:0] K_ADD  = 3'd0;
	localparam logic [2:0] K_SUB  = 3'd1;
	localparam logic [2:0] K_CHK  = 3'd2;
	localparam logic [2:0] K_MUL  = 3'd3;
	localparam logic [2:0] K_DIV  = 3'd4;
	localparam logic [2:0] K_DONE = 3'd5;

	localparam logic [1:0] SAT_NONE = 2'd0;
	localparam logic [1:0] SAT_32   = 2'd1;
	localparam logic [1:0] SAT_48   = 2'd2;

	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_16 = 2'd1;
	localparam logic [1:0] SH_17 = 2'd2;
	localparam logic [1:0] SH_24 = 2'd3;

	// operand / destination selects
	localparam logic [4:0] R_ALT = 5'd0;
	localparam logic [4:0] R_VEL = 5'd1;
	localparam logic [4:0] R_PHH = 5'd2;
	localparam logic [4:0] R_PHV = 5'd3;
	localparam logic [4:0] R_PVH = 5'd4;
	localparam logic [4:0] R_PVV = 5'd5;
	localparam logic [4:0] R_T0  = 5'd6;
	localparam logic [4:0] R_T1  = 5'd7;
	localparam logic [4:0] R_T2  = 5'd8;
	localparam logic [4:0] R_T3  = 5'd9;
	localparam logic [4:0] R_T4  = 5'd10;
	localparam logic [4:0] R_T5  = 5'd11;
	localparam logic [4:0] R_Z   = 5'd12;
	localparam logic [4:0] R_RB  = 5'd13;
	localparam logic [4:0] R_Q   = 5'd14;
	localparam logic [4:0] R_DT  = 5'd15;
	localparam logic [4:0] R_ACC = 5'd16;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] a;
		logic [4:0] b;
		logic [1:0] sh;
		logic [1:0] sat;
		logic [4:0] dst;
	} uop_t;

	function automatic uop_t mk(input logic [2:0] k, input logic [4:0] a, input logic [4:0] b,
			input logic [1:0] sh, input logic [1:0] sat, input logic [4:0] d);
		uop_t u;
		u.kind = k;
		u.a = a;
		u.b = b;
		u.sh = sh;
		u.sat = sat;
		u.dst = d;
		return u;
	endfunction

	function automatic uop_t ucode(input logic [1:0] op, input logic [4:0] step);
		uop_t u;
		u = mk(K_DONE, R_ALT, R_ALT, SH_0, SAT_NONE, R_T0);
		if (op == OP_PREDICT) begin
			case (step)
				5'd0:  u = mk(K_MUL, R_DT,  R_DT, SH_0,  SAT_NONE, R_T0);
				5'd1:  u = mk(K_MUL, R_T0,  R_Q,  SH_24, SAT_NONE, R_T1);
				5'd2:  u = mk(K_MUL, R_T1,  R_DT, SH_17, SAT_NONE, R_T2);
				5'd3:  u = mk(K_MUL, R_T2,  R_DT, SH_17, SAT_NONE, R_T3);
				5'd4:  u = mk(K_MUL, R_VEL, R_DT, SH_16, SAT_NONE, R_T0);
				5'd5:  u = mk(K_ADD, R_ALT, R_T0, SH_0,  SAT_NONE, R_T0);
				5'd6:  u = mk(K_MUL, R_ACC, R_DT, SH_16, SAT_NONE, R_T4);
				5'd7:  u = mk(K_MUL, R_T4,  R_DT, SH_17, SAT_NONE, R_T5);
				5'd8:  u = mk(K_ADD, R_T0,  R_T5, SH_0,  SAT_32,   R_ALT);
				5'd9:  u = mk(K_ADD, R_VEL, R_T4, SH_0,  SAT_32,   R_VEL);
				5'd10: u = mk(K_MUL, R_PVH, R_DT, SH_16, SAT_NONE, R_T0);
				5'd11: u = mk(K_ADD, R_PHH, R_T0, SH_0,  SAT_48,   R_T0);
				5'd12: u = mk(K_MUL, R_PVV, R_DT, SH_16, SAT_NONE, R_T4);
				5'd13: u = mk(K_ADD, R_PVH, R_T4, SH_0,  SAT_NONE, R_T5);
				5'd14: u = mk(K_ADD, R_PHV, R_T4, SH_0,  SAT_48,   R_T4);
				5'd15: u = mk(K_ADD, R_PVV, R_T1, SH_0,  SAT_48,   R_PVV);
				5'd16: u = mk(K_ADD, R_T5,  R_T2, SH_0,  SAT_48,   R_PVH);
				5'd17: u = mk(K_MUL, R_T4,  R_DT, SH_16, SAT_NONE, R_T1);
				5'd18: u = mk(K_ADD, R_T0,  R_T1, SH_0,  SAT_NONE, R_T0);
				5'd19: u = mk(K_ADD, R_T0,  R_T3, SH_0,  SAT_48,   R_PHH);
				5'd20: u = mk(K_ADD, R_T4,  R_T2, SH_0,  SAT_48,   R_PHV);
				default: u = mk(K_DONE, R_ALT, R_ALT, SH_0, SAT_NONE, R_T0);
			endcase
		end else if (op == OP_UPDATE) begin
			case (step)
				5'd0:  u = mk(K_CHK, R_PHH, R_RB,  SH_0,  SAT_NONE, R_T0);
				5'd1:  u = mk(K_DIV, R_PHH, R_T0,  SH_0,  SAT_NONE, R_T1);
				5'd2:  u = mk(K_DIV, R_PVH, R_T0,  SH_0,  SAT_NONE, R_T2);
				5'd3:  u = mk(K_SUB, R_Z,   R_ALT, SH_0,  SAT_NONE, R_T3);
				5'd4:  u = mk(K_MUL, R_T1,  R_T3,  SH_24, SAT_NONE, R_T4);
				5'd5:  u = mk(K_ADD, R_ALT, R_T4,  SH_0,  SAT_32,   R_ALT);
				5'd6:  u = mk(K_MUL, R_T2,  R_T3,  SH_24, SAT_NONE, R_T4);
				5'd7:  u = mk(K_ADD, R_VEL, R_T4,  SH_0,  SAT_32,   R_VEL);
				5'd8:  u = mk(K_MUL, R_T2,  R_PHH, SH_24, SAT_NONE, R_T4);
				5'd9:  u = mk(K_SUB, R_PVH, R_T4,  SH_0,  SAT_48,   R_PVH);
				5'd10: u = mk(K_MUL, R_T2,  R_PHV, SH_24, SAT_NONE, R_T4);
				5'd11: u = mk(K_SUB, R_PVV, R_T4,  SH_0,  SAT_48,   R_PVV);
				5'd12: u = mk(K_MUL, R_T1,  R_PHH, SH_24, SAT_NONE, R_T4);
				5'd13: u = mk(K_SUB, R_PHH, R_T4,  SH_0,  SAT_48,   R_PHH);
				5'd14: u = mk(K_MUL, R_T1,  R_PHV, SH_24, SAT_NONE, R_T4);
				5'd15: u = mk(K_SUB, R_PHV, R_T4,  SH_0,  SAT_48,   R_PHV);
				default: u = mk(K_DONE, R_ALT, R_ALT, SH_0, SAT_NONE, R_T0);
			endcase
		end
		return u;
	endfunction

endpackage

@@ rtl/altitude_kalman_estimator_core.sv @@
// Init and the unused opcode go straight to the output; predict and baro update
// step through micro-op sequences, and an update ends early when it is skipped.
// One item at a time: a 48x16 multiplier and a one-bit-per-cycle divider run
// under a micro-op sequencer.
// The next item is taken while the previous result waits in the output register.
// arst_n clears state to altitude 0, velocity 0, covariance 10*I, registers to defaults.
`include "altitude_kalman_estimator_core_macros.svh"

module altitude_kalman_estimator_core
	import ake_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // accel[31:0], time_step[47:32], baro_altitude[79:48]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // altitude_est[31:0], velocity_est[63:32],
	                              // update_skipped[64], saturated[65], zero pad
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [4:0] step_q;

	logic [30:0]        qvar_q, rvar_q;
	logic signed [31:0] alt0_q, vel0_q;

	logic [1:0]         op_q;
	logic signed [31:0] accel_q, z_q;
	logic [15:0]        dt_q;

	logic signed [31:0] alt_q, vel_q;
	logic signed [47:0] phh_q, phv_q, pvh_q, pvv_q;
	logic signed [63:0] t0_q, t1_q, t2_q, t3_q, t4_q, t5_q;

	logic [47:0] mul_a_q, mul_b_q;
	logic        mul_neg_q;
	logic [95:0] mul_acc_q;
	logic [1:0]  mul_cnt_q;
	logic [63:0] mul_pp;

	logic [47:0] div_d_q, div_rem_q;
	logic [46:0] div_num_q, div_quo_q;
	logic        div_neg_q;
	logic [5:0]  div_cnt_q;

	logic        skip_q, clamp_q;
	logic        m_tvalid_q;
	logic [31:0] out_alt_q, out_vel_q;
	logic        out_skip_q, out_sat_q;

	uop_t uop;
	logic signed [65:0] a_val, b_val, sum, a_abs, b_abs;

	function automatic logic signed [65:0] pick(input logic [4:0] sel);
		logic signed [65:0] v;
		case (sel)
			R_ALT: v = 66'(alt_q);
			R_VEL: v = 66'(vel_q);
			R_PHH: v = 66'(phh_q);
			R_PHV: v = 66'(phv_q);
			R_PVH: v = 66'(pvh_q);
			R_PVV: v = 66'(pvv_q);
			R_T0:  v = 66'(t0_q);
			R_T1:  v = 66'(t1_q);
			R_T2:  v = 66'(t2_q);
			R_T3:  v = 66'(t3_q);
			R_T4:  v = 66'(t4_q);
			R_T5:  v = 66'(t5_q);
			R_Z:   v = 66'(z_q);
			R_RB:  v = $signed(66'({rvar_q, 8'd0}));
			R_Q:   v = $signed(66'(qvar_q));
			R_DT:  v = $signed(66'(dt_q));
			R_ACC: v = 66'(accel_q);
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		uop = ucode(op_q, step_q);
		a_val = pick(uop.a);
		b_val = pick(uop.b);
		sum = (uop.kind == K_SUB) ? a_val - b_val : a_val + b_val;
		a_abs = a_val[65] ? -a_val : a_val;
		b_abs = b_val[65] ? -b_val : b_val;
	end

	// 48x16 partial product, top digit of the multiplier
	assign mul_pp = mul_a_q * mul_b_q[47:32];

	// multiplier finish: round half away, shift, cap magnitude at 2^62
	logic [96:0]        mul_rnd, mul_sh;
	logic [62:0]        mul_mag;
	logic signed [65:0] mul_val;
	always_comb begin
		case (uop.sh)
			SH_16:   mul_rnd = {1'b0, mul_acc_q} + (97'd1 << 15);
			SH_17:   mul_rnd = {1'b0, mul_acc_q} + (97'd1 << 16);
			SH_24:   mul_rnd = {1'b0, mul_acc_q} + (97'd1 << 23);
			default: mul_rnd = {1'b0, mul_acc_q};
		endcase
		case (uop.sh)
			SH_16:   mul_sh = mul_rnd >> 16;
			SH_17:   mul_sh = mul_rnd >> 17;
			SH_24:   mul_sh = mul_rnd >> 24;
			default: mul_sh = mul_rnd;
		endcase
		mul_mag = (mul_sh > PROD_CAP) ? PROD_CAP[62:0] : mul_sh[62:0];
		mul_val = mul_neg_q ? -$signed(66'(mul_mag)) : $signed(66'(mul_mag));
	end

	// divider: restoring step, overflow check up front
	logic [47:0] div_n;
	logic        div_ovf;
	logic [48:0] div_trial;
	logic        div_ge;
	logic [47:0] div_rem_nx;
	logic [46:0] div_quo_nx;
	logic signed [65:0] div_val, ovf_val;
	always_comb begin
		div_n = a_abs[47:0];
		div_ovf = {23'd0, div_n} >= {b_val[47:0], 23'd0};
		ovf_val = a_val[65] ? -$signed(66'(GAIN_MAX)) : $signed(66'(GAIN_MAX));
		div_trial = {div_rem_q, div_num_q[46]};
		div_ge = div_trial >= {1'b0, div_d_q};
		div_rem_nx = div_ge ? 48'(div_trial - {1'b0, div_d_q}) : div_trial[47:0];
		div_quo_nx = {div_quo_q[45:0], div_ge};
		div_val = div_neg_q ? -$signed(66'(div_quo_nx)) : $signed(66'(div_quo_nx));
	end

	// register write path with saturation
	logic               wr_en, wr_clamp;
	logic [1:0]         wr_sat;
	logic signed [65:0] wr_raw, wr_val;
	always_comb begin
		wr_en = 1'b0;
		wr_sat = SAT_NONE;
		wr_raw = sum;
		case (state_q)
			ST_EXEC: begin
				if (uop.kind == K_ADD || uop.kind == K_SUB) begin
					wr_en = 1'b1;
					wr_sat = uop.sat;
				end else if (uop.kind == K_CHK) begin
					wr_en = (sum >= S_MIN);
				end else if (uop.kind == K_DIV) begin
					wr_en = div_ovf;
					wr_raw = ovf_val;
				end
			end
			ST_MUL: begin
				wr_en = (mul_cnt_q == 2'd3);
				wr_raw = mul_val;
			end
			ST_DIV: begin
				wr_en = (div_cnt_q == 6'd46);
				wr_raw = div_val;
			end
			default: wr_en = 1'b0;
		endcase
		wr_val = wr_raw;
		wr_clamp = 1'b0;
		if (wr_sat == SAT_32) begin
			if (wr_raw > S32_MAX) begin wr_val = S32_MAX; wr_clamp = 1'b1; end
			else if (wr_raw < S32_MIN) begin wr_val = S32_MIN; wr_clamp = 1'b1; end
		end else if (wr_sat == SAT_48) begin
			if (wr_raw > S48_MAX) begin wr_val = S48_MAX; wr_clamp = 1'b1; end
			else if (wr_raw < S48_MIN) begin wr_val = S48_MIN; wr_clamp = 1'b1; end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {6'd0, out_sat_q, out_skip_q, out_vel_q, out_alt_q};

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qvar_q <= QVAR_RST;
			rvar_q <= RVAR_RST;
			alt0_q <= '0;
			vel0_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_QVAR: qvar_q <= cfg_data[30:0];
				CFG_RVAR: rvar_q <= cfg_data[30:0];
				CFG_ALT0: alt0_q <= cfg_data;
				CFG_VEL0: vel0_q <= cfg_data;
				default:  qvar_q <= qvar_q;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			alt_q <= '0;
			vel_q <= '0;
			phh_q <= COV_TEN;
			phv_q <= '0;
			pvh_q <= '0;
			pvv_q <= COV_TEN;
			skip_q <= 1'b0;
			clamp_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			mul_cnt_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			if (wr_en) begin
				clamp_q <= clamp_q | wr_clamp;
				case (uop.dst)
					R_ALT: alt_q <= wr_val[31:0];
					R_VEL: vel_q <= wr_val[31:0];
					R_PHH: phh_q <= wr_val[47:0];
					R_PHV: phv_q <= wr_val[47:0];
					R_PVH: pvh_q <= wr_val[47:0];
					R_PVV: pvv_q <= wr_val[47:0];
					R_T0:  t0_q <= wr_val[63:0];
					R_T1:  t1_q <= wr_val[63:0];
					R_T2:  t2_q <= wr_val[63:0];
					R_T3:  t3_q <= wr_val[63:0];
					R_T4:  t4_q <= wr_val[63:0];
					R_T5:  t5_q <= wr_val[63:0];
					default: t5_q <= t5_q;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q <= s_tuser;
						accel_q <= s_tdata[31:0];
						dt_q <= s_tdata[47:32];
						z_q <= s_tdata[79:48];
						step_q <= '0;
						skip_q <= 1'b0;
						clamp_q <= 1'b0;
						if (s_tuser == OP_INIT) begin
							alt_q <= alt0_q;
							vel_q <= vel0_q;
							phh_q <= COV_TEN;
							phv_q <= '0;
							pvh_q <= '0;
							pvv_q <= COV_TEN;
							state_q <= ST_OUT;
						end else if (s_tuser == OP_PREDICT || s_tuser == OP_UPDATE) begin
							state_q <= ST_EXEC;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_EXEC: begin
					case (uop.kind)
						K_ADD, K_SUB: step_q <= step_q + 5'd1;
						K_CHK: begin
							if (sum < S_MIN) begin
								skip_q <= 1'b1;
								state_q <= ST_OUT;
							end else begin
								step_q <= step_q + 5'd1;
							end
						end
						K_MUL: begin
							mul_a_q <= a_abs[47:0];
							mul_b_q <= b_abs[47:0];
							mul_neg_q <= a_val[65] ^ b_val[65];
							mul_acc_q <= '0;
							mul_cnt_q <= '0;
							state_q <= ST_MUL;
						end
						K_DIV: begin
							if (div_ovf) begin
								step_q <= step_q + 5'd1;
							end else begin
								div_d_q <= b_val[47:0];
								div_rem_q <= {23'd0, div_n[47:23]};
								div_num_q <= {div_n[22:0], 24'd0};
								div_quo_q <= '0;
								div_neg_q <= a_val[65];
								div_cnt_q <= '0;
								state_q <= ST_DIV;
							end
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_MUL: begin
					// top 16-bit digit of the multiplier first
					if (mul_cnt_q == 2'd3) begin
						step_q <= step_q + 5'd1;
						state_q <= ST_EXEC;
					end else begin
						mul_acc_q <= (mul_acc_q << 16) + 96'(mul_pp);
						mul_b_q <= mul_b_q << 16;
						mul_cnt_q <= mul_cnt_q + 2'd1;
					end
				end
				ST_DIV: begin
					div_rem_q <= div_rem_nx;
					div_num_q <= div_num_q << 1;
					div_quo_q <= div_quo_nx;
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd46) begin
						step_q <= step_q + 5'd1;
						state_q <= ST_EXEC;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						out_alt_q <= alt_q;
						out_vel_q <= vel_q;
						out_skip_q <= skip_q;
						out_sat_q <= clamp_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`AKE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, state_q != ST_IDLE, "accepted beat left block idle")
	`AKE_ASSERT_NEXT(a_predict_runs, s_tvalid && s_tready && s_tuser == OP_PREDICT, state_q == ST_EXEC, "predict did not start")
	`AKE_ASSERT(a_div_rem_lt_d, state_q == ST_DIV, div_rem_q < div_d_q, "divider remainder not below divisor")
	`AKE_ASSERT(a_mul_only_from_uop, state_q == ST_MUL, uop.kind == K_MUL, "multiplier running on a non-multiply step")

endmodule

@@ sim/tb_altitude_kalman_estimator_core.sv @@
module tb_altitude_kalman_estimator_core
	import ake_pkg::*;
;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;
	localparam longint S48_HI = 64'sd140737488355327;
	localparam longint S48_LO = -64'sd140737488355328;
	localparam longint ONE_TEN = 64'sd167772160;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] accel;
		logic [15:0] dt;
		logic [31:0] baro;
	} meas_t;

	typedef struct packed {
		logic [31:0] alt;
		logic [31:0] vel;
		logic        skip;
		logic        sat;
	} est_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [31:0] cfg_data;

	altitude_kalman_estimator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	meas_t pending_meas[$];
	est_t  expected_est[$];
	int    errors = 0;
	int    idle_pct = 20;
	bit    hold_req = 0;
	bit    hold_used = 0;
	int    hold_cnt = 0;
	int    quiet_cnt = 0;
	bit    s_tready_seen = 0;
	est_t  got;

	// filter state mirrored from the block's behavior
	longint q_var, r_var, alt0, vel0;
	longint alt, vel, phh, phv, pvh, pvv;
	bit     clamped;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint rmul(input longint a, input longint b, input int s);
		logic [127:0] ua, ub, p;
		bit neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 128'(-a) : 128'(a);
		ub = (b < 0) ? 128'(-b) : 128'(b);
		p = ua * ub;
		p = (p + (128'd1 << (s - 1))) >> s;
		if (p > (128'd1 << 62))
			p = 128'd1 << 62;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint gain(input longint p, input longint s);
		logic [127:0] n, q;
		n = (p < 0) ? 128'(-p) : 128'(p);
		q = n / 128'(s);
		if (q >= (128'd1 << 23))
			q = 128'(S48_HI);
		else
			q = (n << 24) / 128'(s);
		return (p < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		if (x > hi) begin
			clamped = 1;
			return hi;
		end
		if (x < lo) begin
			clamped = 1;
			return lo;
		end
		return x;
	endfunction

	function automatic est_t estimate(input meas_t m);
		est_t e;
		longint dt, a, z, vdt, adt, n11, n01, n00, f00, f01, n_hh, n_hv, n_vh, n_vv;
		longint s, k0, k1;
		e.skip = 0;
		clamped = 0;
		case (m.op)
			OP_INIT: begin
				alt = alt0;
				vel = vel0;
				phh = ONE_TEN;
				phv = 0;
				pvh = 0;
				pvv = ONE_TEN;
			end
			OP_PREDICT: begin
				dt = longint'(m.dt);
				a = longint'($signed(m.accel));
				vdt = rmul(vel, dt, 16);
				adt = rmul(a, dt, 16);
				n11 = rmul(dt * dt, q_var, 24);
				n01 = rmul(n11, dt, 17);
				n00 = rmul(n01, dt, 17);
				f00 = clip(phh + rmul(pvh, dt, 16), S48_LO, S48_HI);
				f01 = clip(phv + rmul(pvv, dt, 16), S48_LO, S48_HI);
				n_hh = clip(f00 + rmul(f01, dt, 16) + n00, S48_LO, S48_HI);
				n_hv = clip(f01 + n01, S48_LO, S48_HI);
				n_vh = clip(pvh + rmul(pvv, dt, 16) + n01, S48_LO, S48_HI);
				n_vv = clip(pvv + n11, S48_LO, S48_HI);
				alt = clip(alt + vdt + rmul(adt, dt, 17), S32_LO, S32_HI);
				vel = clip(vel + adt, S32_LO, S32_HI);
				phh = n_hh;
				phv = n_hv;
				pvh = n_vh;
				pvv = n_vv;
			end
			OP_UPDATE: begin
				z = longint'($signed(m.baro)) - alt;
				s = phh + (r_var <<< 8);
				if (s < 17) begin
					e.skip = 1;
				end else begin
					k0 = gain(phh, s);
					k1 = gain(pvh, s);
					alt = clip(alt + rmul(k0, z, 24), S32_LO, S32_HI);
					vel = clip(vel + rmul(k1, z, 24), S32_LO, S32_HI);
					n_hh = clip(phh - rmul(k0, phh, 24), S48_LO, S48_HI);
					n_hv = clip(phv - rmul(k0, phv, 24), S48_LO, S48_HI);
					n_vh = clip(pvh - rmul(k1, phh, 24), S48_LO, S48_HI);
					n_vv = clip(pvv - rmul(k1, phv, 24), S48_LO, S48_HI);
					phh = n_hh;
					phv = n_hv;
					pvh = n_vh;
					pvv = n_vv;
				end
			end
			default: ;
		endcase
		e.alt = alt[31:0];
		e.vel = vel[31:0];
		e.sat = clamped;
		return e;
	endfunction

	// sender: new beat at falling edge once the previous one is gone
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_tready_seen)) begin
			if (pending_meas.size() > 0 && $urandom_range(99) >= idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= {pending_meas[0].baro, pending_meas[0].dt, pending_meas[0].accel};
				s_tuser <= pending_meas[0].op;
				void'(pending_meas.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && !hold_used) begin
			hold_used <= 1;
			hold_cnt <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		s_tready_seen = s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			got.alt = m_tdata[31:0];
			got.vel = m_tdata[63:32];
			got.skip = m_tdata[64];
			got.sat = m_tdata[65];
			if (expected_est.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat alt=%h vel=%h", got.alt, got.vel);
			end else begin
				if (got != expected_est[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp alt=%h vel=%h skip=%b sat=%b, got alt=%h vel=%h skip=%b sat=%b",
							expected_est[0].alt, expected_est[0].vel, expected_est[0].skip,
							expected_est[0].sat, got.alt, got.vel, got.skip, got.sat);
				end
				void'(expected_est.pop_front());
			end
		end
		if (s_tvalid && s_tready) begin
			meas_t m;
			m.accel = s_tdata[31:0];
			m.dt = s_tdata[47:32];
			m.baro = s_tdata[79:48];
			m.op = s_tuser;
			expected_est.push_back(estimate(m));
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cnt = 0;
		else if (++quiet_cnt >= IDLE_LIMIT) begin
			$display("altitude_kalman_estimator_core verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			CFG_QVAR: q_var = longint'(val[30:0]);
			CFG_RVAR: r_var = longint'(val[30:0]);
			CFG_ALT0: alt0 = longint'($signed(val));
			default: vel0 = longint'($signed(val));
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick32(input int wide);
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2, 3: return $urandom;
			default: return wide ? $urandom : 32'($signed($urandom_range(2 ** 22)) - (2 ** 21));
		endcase
	endfunction

	function automatic logic [15:0] pick_dt();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hffff;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(1500));
		endcase
	endfunction

	task automatic queue_meas(input logic [1:0] op, input logic [31:0] a, input logic [15:0] dt,
			input logic [31:0] z);
		meas_t m;
		m.op = op;
		m.accel = a;
		m.dt = dt;
		m.baro = z;
		pending_meas.push_back(m);
	endtask

	task automatic queue_flight(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 3)
				queue_meas(OP_INIT, $urandom, 16'($urandom), $urandom);
			else if (r < 5)
				queue_meas(OP_SPARE, $urandom, 16'($urandom), $urandom);
			else if (r < 70)
				queue_meas(OP_PREDICT, pick32(0), pick_dt(), $urandom);
			else
				queue_meas(OP_UPDATE, $urandom, 16'($urandom), pick32(0));
		end
	endtask

	task automatic drain();
		while (pending_meas.size() != 0 || s_tvalid || expected_est.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_INIT;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = CFG_QVAR;
		cfg_data = '0;
		q_var = 65536;
		r_var = 65536;
		alt0 = 0;
		vel0 = 0;
		alt = 0;
		vel = 0;
		phh = ONE_TEN;
		phv = 0;
		pvh = 0;
		pvv = ONE_TEN;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every opcode, field extremes, saturation, skipped update
		queue_meas(OP_PREDICT, 32'h00010000, 16'h8000, 32'h0);
		queue_meas(OP_UPDATE, 32'h0, 16'h0, 32'h00050000);
		queue_meas(OP_SPARE, 32'hffffffff, 16'hffff, 32'hffffffff);
		queue_meas(OP_PREDICT, 32'h7fffffff, 16'hffff, 32'h0);
		queue_meas(OP_PREDICT, 32'h7fffffff, 16'hffff, 32'h0);
		queue_meas(OP_PREDICT, 32'h80000000, 16'hffff, 32'h0);
		queue_meas(OP_PREDICT, 32'h80000000, 16'h0000, 32'h0);
		queue_meas(OP_UPDATE, 32'h0, 16'h0, 32'h80000000);
		queue_meas(OP_UPDATE, 32'h0, 16'h0, 32'h7fffffff);
		queue_meas(OP_INIT, 32'h0, 16'h0, 32'h0);
		drain();
		write_reg(CFG_QVAR, 32'h7fffffff);
		write_reg(CFG_RVAR, 32'h0);
		write_reg(CFG_ALT0, 32'h7fffffff);
		write_reg(CFG_VEL0, 32'h80000000);
		queue_meas(OP_INIT, 32'h0, 16'h0, 32'h0);
		queue_meas(OP_UPDATE, 32'h0, 16'h0, 32'h80000000);
		queue_meas(OP_UPDATE, 32'h0, 16'h0, 32'h12345678);  // zero variance: skipped
		queue_meas(OP_PREDICT, 32'h0, 16'h0000, 32'h0);
		queue_meas(OP_UPDATE, 32'h0, 16'h0, 32'h0);
		queue_meas(OP_PREDICT, 32'h7fffffff, 16'hffff, 32'h0);
		queue_meas(OP_PREDICT, 32'h7fffffff, 16'hffff, 32'h0);
		queue_meas(OP_UPDATE, 32'h0, 16'h0, 32'h7fffffff);
		queue_meas(OP_SPARE, 32'h0, 16'h0, 32'h0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_QVAR, ph == 1 ? 32'h0 : (ph == 2 ? 32'h7fffffff : $urandom_range(1 << 20)));
			write_reg(CFG_RVAR, (ph == 3 || ph == 6) ? 32'h0 :
				(ph == 4 ? 32'h7fffffff : $urandom_range(1 << 20)));
			write_reg(CFG_ALT0, ph == 5 ? 32'h80000000 : pick32(0));
			write_reg(CFG_VEL0, ph == 5 ? 32'h7fffffff : pick32(0));
			idle_pct = (ph == 2) ? 0 : 20;
			queue_meas(OP_INIT, 32'h0, 16'h0, 32'h0);
			if (ph == 4) begin
				queue_flight(30);
				hold_req = 1;
				idle_pct = 2;
			end
			queue_flight(ph == 4 ? 180 : 210);
			drain();
		end
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("altitude_kalman_estimator_core verification clean");
		else
			$display("altitude_kalman_estimator_core verification failed");
		$finish;
	end

endmodule

@@ altitude_kalman_estimator_core.f @@
+incdir+rtl
rtl/ake_pkg.sv
rtl/altitude_kalman_estimator_core.sv
sim/tb_altitude_kalman_estimator_core.sv
